// ===== sv/ctut_pkg.sv =====
// ctut_pkg: shared widths, constants, the month offset table and the word
// types passed between the front end, the queues and the back end.
// No dependencies.
`default_nettype none

package ctut_pkg;

  // Field widths
  localparam int YEAR_W   = 12;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int SECOND_W = 6;
  localparam int ZONE_W   = 11;
  localparam int SECS_W   = 32;
  localparam int WDAY_W   = 3;

  // Internal widths
  localparam int SHIFTED_W = 13;  // year + march flag + 30, never negative
  localparam int YDIFF_W   = 13;  // year - 1970, two's complement
  localparam int DM_W      = 9;   // days before month, at most 426
  localparam int OFFMIN_W  = 12;  // zone offset in minutes, signed
  localparam int WSUM_W    = 13;  // weekday sum before reduction mod 7
  localparam int DAYS_W    = 22;  // day count since epoch, signed
  localparam int TOD_W     = 19;  // second of day less zone, signed

  // Calendar constants
  localparam int EPOCH_YEAR     = 1970;
  localparam int WDAY_BASE_YEAR = 2000;
  localparam int YEAR_BIAS      = 30;   // shifted year = (year - 1970) + 2000
  localparam int DAYS_BIAS      = 486;  // bias of the three floor terms and of day 1
  localparam int ZONE_HOUR_MAX  = 12;
  localparam int WDAY_BIAS      = 4;
  localparam int DAYS_PER_YEAR  = 365;
  localparam int SECS_PER_DAY   = 86400;
  localparam int SECS_PER_HOUR  = 3600;
  localparam int SECS_PER_MIN   = 60;
  localparam int MARCH          = 3;

  // Reciprocal constants for division by 100 and by 7
  localparam int RECIP100    = 5243;
  localparam int RECIP100_SH = 19;
  localparam int RECIP7      = 9363;
  localparam int RECIP7_SH   = 16;

  typedef struct packed {
    logic [SHIFTED_W-1:0] shifted_year;
    logic [YDIFF_W-1:0]   year_diff;
    logic [DM_W-1:0]      days_before;
    logic [DAY_W-1:0]     day;
    logic [HOUR_W-1:0]    hour;
    logic [MINUTE_W-1:0]  minute;
    logic [SECOND_W-1:0]  second;
    logic [OFFMIN_W-1:0]  offset_min;
    logic [WSUM_W-1:0]    wday_sum;
  } ctut_item_t;

  typedef struct packed {
    logic [SECS_W-1:0] unix_seconds;
    logic [WDAY_W-1:0] weekday_num;
  } ctut_result_t;

  // Days in the year before the first of the given month (non-leap);
  // months beyond December carry on the alternating 30/31 pattern.
  function automatic logic [DM_W-1:0] days_before_month(input logic [MONTH_W-1:0] month);
    logic [DM_W-1:0] dm;
    unique case (month)
      4'd0:    dm = 9'd0;
      4'd1:    dm = 9'd0;
      4'd2:    dm = 9'd31;
      4'd3:    dm = 9'd59;
      4'd4:    dm = 9'd90;
      4'd5:    dm = 9'd120;
      4'd6:    dm = 9'd151;
      4'd7:    dm = 9'd181;
      4'd8:    dm = 9'd212;
      4'd9:    dm = 9'd243;
      4'd10:   dm = 9'd273;
      4'd11:   dm = 9'd304;
      4'd12:   dm = 9'd334;
      4'd13:   dm = 9'd365;
      4'd14:   dm = 9'd395;
      4'd15:   dm = 9'd426;
      default: dm = 9'd0;
    endcase
    return dm;
  endfunction

endpackage

`default_nettype wire

// ===== sv/calendar_to_unix_time.sv =====
// Converts a calendar date and time of day into a Unix seconds count (less a
// programmable zone offset, wrapping at 2^32) and a weekday, 1 = Monday.
// Depends on ctut_pkg, ctut_front, ctut_queue and ctut_back.
`default_nettype none

// One timestamp word may be pushed every clock cycle while full is low and,
// with pop held high, one result word leaves every cycle; the rate is set by
// the back-end pipeline, which takes one word a cycle from the front queue.
// A word pushed into an empty block goes through the front queue, both
// back-end stages and the result queue. The zone offset is taken as hours
// when its magnitude is 12 or less and as minutes otherwise; write it only
// while the block is idle. Weekdays follow the every-fourth-year rule and
// are right for years 2000 to 2099. Full stays low while the front queue
// (MID_DEPTH words) has room; a result queue (OUT_DEPTH words, at least
// four for one word a cycle) short of room stalls the back end.
module calendar_to_unix_time #(
  parameter int MID_DEPTH = 2,
  parameter int OUT_DEPTH = 4
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [ctut_pkg::ZONE_W-1:0]     cfg_wdata,
  input  logic                            push,
  output logic                            full,
  input  logic [ctut_pkg::YEAR_W-1:0]     year_full,
  input  logic [ctut_pkg::MONTH_W-1:0]    month_num,
  input  logic [ctut_pkg::DAY_W-1:0]      day_of_month,
  input  logic [ctut_pkg::HOUR_W-1:0]     hour_num,
  input  logic [ctut_pkg::MINUTE_W-1:0]   minute_num,
  input  logic [ctut_pkg::SECOND_W-1:0]   second_num,
  output logic                            empty,
  input  logic                            pop,
  output logic [ctut_pkg::SECS_W-1:0]     unix_seconds,
  output logic [ctut_pkg::WDAY_W-1:0]     weekday_num
);

  import ctut_pkg::*;

  localparam int ITEM_W = $bits(ctut_item_t);
  localparam int RES_W  = $bits(ctut_result_t);

  ctut_item_t                   front_item;
  ctut_item_t                   mid_item;
  logic                         mid_empty;
  logic                         mid_pop;
  logic [$clog2(MID_DEPTH+1)-1:0] mid_count;
  ctut_result_t                 back_res;
  logic                         back_push;
  ctut_result_t                 out_res;
  logic [$clog2(OUT_DEPTH+1)-1:0] out_count;
  logic                         out_full;

  // Classify incoming words
  ctut_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .year_full    (year_full),
    .month_num    (month_num),
    .day_of_month (day_of_month),
    .hour_num     (hour_num),
    .minute_num   (minute_num),
    .second_num   (second_num),
    .item         (front_item)
  );

  // Decouple front and back
  ctut_queue #(
    .DEPTH (MID_DEPTH),
    .WIDTH (ITEM_W)
  ) u_mid_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (front_item),
    .full  (full),
    .pop   (mid_pop),
    .rdata (mid_item),
    .empty (mid_empty),
    .count (mid_count)
  );

  // Compute results
  ctut_back #(
    .OUT_DEPTH (OUT_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (!mid_empty && (mid_count != '0)),
    .item       (mid_item),
    .item_pop   (mid_pop),
    .out_count  (out_count),
    .res_push   (back_push),
    .res        (back_res)
  );

  // Hold finished words until popped
  ctut_queue #(
    .DEPTH (OUT_DEPTH),
    .WIDTH (RES_W)
  ) u_out_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (back_push),
    .wdata (back_res),
    .full  (out_full),
    .pop   (pop),
    .rdata (out_res),
    .empty (empty),
    .count (out_count)
  );

  assign unix_seconds = out_res.unix_seconds;
  // Result queue never overflows: the back end issues against its free space
  assign weekday_num  = out_full ? out_res.weekday_num : out_res.weekday_num;

endmodule

`default_nettype wire

// ===== sv/ctut_queue.sv =====
// ctut_queue: small first-in first-out store of fixed-width words.
// No package dependencies.
`default_nettype none

module ctut_queue #(
  parameter int DEPTH = 2,
  parameter int WIDTH = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wdata,
  output logic                       full,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rdata,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = store[rd_ptr];

  // Write the incoming word at the tail
  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= wdata;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/ctut_front.sv =====
// ctut_front: holds the zone offset register and classifies each incoming
// timestamp into the word the back end works on. Depends on ctut_pkg.
`default_nettype none

module ctut_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [ctut_pkg::ZONE_W-1:0]    cfg_wdata,
  input  logic [ctut_pkg::YEAR_W-1:0]    year_full,
  input  logic [ctut_pkg::MONTH_W-1:0]   month_num,
  input  logic [ctut_pkg::DAY_W-1:0]     day_of_month,
  input  logic [ctut_pkg::HOUR_W-1:0]    hour_num,
  input  logic [ctut_pkg::MINUTE_W-1:0]  minute_num,
  input  logic [ctut_pkg::SECOND_W-1:0]  second_num,
  output ctut_pkg::ctut_item_t           item
);

  import ctut_pkg::*;

  logic [ZONE_W-1:0]   zone;
  logic [OFFMIN_W-1:0] zone_ext;
  logic [OFFMIN_W-1:0] zone_hours;
  logic                zone_is_hours;
  logic                after_feb;
  logic [DM_W-1:0]     dm;
  logic [YEAR_W-1:0]   wy;
  logic                wleap;
  logic [WSUM_W-1:0]   wy_ext;

  // Hold the zone offset
  always_ff @(posedge clk) begin
    if (rst) begin
      zone <= '0;
    end else if (cfg_we) begin
      zone <= cfg_wdata;
    end
  end

  // Read small offsets as hours, anything wider as minutes
  always_comb begin
    zone_ext      = {zone[ZONE_W-1], zone};
    zone_hours    = OFFMIN_W'($signed(zone_ext) * $signed(OFFMIN_W'(SECS_PER_MIN)));
    zone_is_hours = ($signed(zone) <= $signed(ZONE_W'(ZONE_HOUR_MAX)))
                 && ($signed(zone) >= -$signed(ZONE_W'(ZONE_HOUR_MAX)));
  end

  // Classify the date fields
  always_comb begin
    after_feb = (month_num >= MONTH_W'(MARCH));
    dm        = days_before_month(month_num);
    wy        = (year_full >= YEAR_W'(WDAY_BASE_YEAR)) ?
                year_full - YEAR_W'(WDAY_BASE_YEAR) : year_full;
    wleap     = after_feb && (wy[1:0] == 2'b00);
    wy_ext    = WSUM_W'(wy);

    item.shifted_year = SHIFTED_W'(year_full) + SHIFTED_W'(after_feb)
                      + SHIFTED_W'(YEAR_BIAS);
    item.year_diff    = YDIFF_W'(year_full) - YDIFF_W'(EPOCH_YEAR);
    item.days_before  = dm;
    item.day          = day_of_month;
    item.hour         = hour_num;
    item.minute       = minute_num;
    item.second       = second_num;
    item.offset_min   = zone_is_hours ? zone_hours : zone_ext;
    // 365 is 1 mod 7, so the year term reduces to the year itself
    item.wday_sum     = WSUM_W'(day_of_month) + WSUM_W'(dm) + WSUM_W'(wleap)
                      + wy_ext + ((wy_ext + WSUM_W'(3)) >> 2)
                      + WSUM_W'(WDAY_BIAS);
  end

endmodule

`default_nettype wire

// ===== sv/ctut_back.sv =====
// ctut_back: two-stage arithmetic pipeline that turns a classified word
// into seconds and weekday, issuing only when the result queue has room.
// Depends on ctut_pkg.
`default_nettype none

module ctut_back #(
  parameter int OUT_DEPTH = 4
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             item_valid,
  input  ctut_pkg::ctut_item_t             item,
  output logic                             item_pop,
  input  logic [$clog2(OUT_DEPTH+1)-1:0]   out_count,
  output logic                             res_push,
  output ctut_pkg::ctut_result_t           res
);

  import ctut_pkg::*;

  localparam int CNT_W  = $clog2(OUT_DEPTH + 1);
  localparam int OCC_W  = CNT_W + 2;
  localparam int Q4_W   = 11;
  localparam int Q100_W = 7;
  localparam int Q400_W = 4;
  localparam int P100_W = 26;
  localparam int P7_W   = 27;
  localparam int Q7_W   = 10;

  // Stage one registers
  logic                 v1;
  logic [Q4_W-1:0]      s1_q4;
  logic [Q100_W-1:0]    s1_q100;
  logic [Q400_W-1:0]    s1_q400;
  logic [DAYS_W-1:0]    s1_y365;
  logic [TOD_W-1:0]     s1_tod;
  logic [DM_W-1:0]      s1_dm;
  logic [DAY_W-1:0]     s1_day;
  logic [WSUM_W-1:0]    s1_wsum;
  logic [Q7_W-1:0]      s1_q7;

  // Stage two registers
  logic                 v2;
  logic [DAYS_W-1:0]    s2_days;
  logic [TOD_W-1:0]     s2_tod;
  logic [WDAY_W-1:0]    s2_wday;

  logic [OCC_W-1:0]     occupancy;
  logic [SHIFTED_W-1:0] sy_p1;
  logic [P100_W-1:0]    p100a;
  logic [P100_W-1:0]    p100b;
  logic [P7_W-1:0]      p7;
  logic [TOD_W-1:0]     off_secs;
  logic [TOD_W-1:0]     tod_raw;
  logic [DAYS_W-1:0]    y365;
  logic [WSUM_W-1:0]    wrem;
  logic [DAYS_W-1:0]    days;

  // Issue only when every word in flight has a place in the result queue
  assign occupancy = OCC_W'(out_count) + OCC_W'(v1) + OCC_W'(v2);
  assign item_pop  = item_valid && (occupancy < OCC_W'(OUT_DEPTH));

  // Stage one: floor divisions by reciprocal, year days, second of day
  always_comb begin
    sy_p1    = item.shifted_year + SHIFTED_W'(1);
    p100a    = (P100_W'(item.shifted_year) + P100_W'(69)) * P100_W'(RECIP100);
    p100b    = (P100_W'(item.shifted_year) + P100_W'(369)) * P100_W'(RECIP100);
    p7       = P7_W'(item.wday_sum) * P7_W'(RECIP7);
    y365     = {{(DAYS_W-YDIFF_W){item.year_diff[YDIFF_W-1]}}, item.year_diff}
             * DAYS_W'(DAYS_PER_YEAR);
    off_secs = {{(TOD_W-OFFMIN_W){item.offset_min[OFFMIN_W-1]}}, item.offset_min}
             * TOD_W'(SECS_PER_MIN);
    tod_raw  = TOD_W'(item.hour) * TOD_W'(SECS_PER_HOUR)
             + TOD_W'(item.minute) * TOD_W'(SECS_PER_MIN)
             + TOD_W'(item.second) - off_secs;
  end

  always_ff @(posedge clk) begin
    if (item_pop) begin
      s1_q4   <= Q4_W'(sy_p1 >> 2);
      s1_q100 <= p100a[RECIP100_SH +: Q100_W];
      s1_q400 <= p100b[RECIP100_SH + 2 +: Q400_W];
      s1_y365 <= y365;
      s1_tod  <= tod_raw;
      s1_dm   <= item.days_before;
      s1_day  <= item.day;
      s1_wsum <= item.wday_sum;
      s1_q7   <= p7[RECIP7_SH +: Q7_W];
    end
  end

  // Stage two: sum the day count, reduce the weekday
  always_comb begin
    days = DAYS_W'(s1_day) + DAYS_W'(s1_dm) + DAYS_W'(s1_q4) - DAYS_W'(s1_q100)
         + DAYS_W'(s1_q400) + s1_y365 - DAYS_W'(DAYS_BIAS);
    wrem = s1_wsum - WSUM_W'(s1_q7) * WSUM_W'(7);
  end

  always_ff @(posedge clk) begin
    if (v1) begin
      s2_days <= days;
      s2_tod  <= s1_tod;
      s2_wday <= wrem[WDAY_W-1:0] + WDAY_W'(1);
    end
  end

  // Advance the valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= item_pop;
      v2 <= v1;
    end
  end

  // Scale days to seconds and add the time of day, wrapping at 32 bits
  assign res_push         = v2;
  assign res.unix_seconds = {{(SECS_W-DAYS_W){s2_days[DAYS_W-1]}}, s2_days}
                          * SECS_W'(SECS_PER_DAY)
                          + {{(SECS_W-TOD_W){s2_tod[TOD_W-1]}}, s2_tod};
  assign res.weekday_num  = s2_wday;

endmodule

`default_nettype wire

// ===== sv/ctut_check.sv =====
// ctut_check: port-level assertions for calendar_to_unix_time, with the bind
// that attaches them. Depends on ctut_pkg.
`default_nettype none

module ctut_check (
  input logic                          clk,
  input logic                          rst,
  input logic                          push,
  input logic                          full,
  input logic                          pop,
  input logic                          empty,
  input logic [ctut_pkg::SECS_W-1:0]   unix_seconds,
  input logic [ctut_pkg::WDAY_W-1:0]   weekday_num
);

  // Reset leaves no result waiting
  assert property (@(posedge clk) rst |=> empty)
    else $error("result shown straight after reset");

  // Reset leaves the input side open
  assert property (@(posedge clk) rst |=> !full)
    else $error("input full straight after reset");

  // A shown weekday is never zero
  assert property (@(posedge clk) disable iff (rst) !empty |-> (weekday_num != '0))
    else $error("weekday out of range");

  // A waiting word holds until popped
  assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(unix_seconds) && $stable(weekday_num)))
    else $error("waiting result changed before pop");

endmodule

bind calendar_to_unix_time ctut_check u_check (.*);

`default_nettype wire
